### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the byte stream hash.
// Depends on nothing; included by modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/sha256_pkg.sv
// Package for the byte stream hash: round constants, initial hash and helpers.
// Depends on nothing; used by the round core and the top level.
package sha256_pkg;

   localparam int unsigned WORD_W = 32;
   localparam int unsigned NUM_ROUNDS = 64;
   localparam int unsigned BLOCK_BYTES = 64;

   localparam logic [7:0] PAD_BYTE = 8'h80;

   typedef logic [WORD_W-1:0] word_type;

   typedef struct packed {
      logic start;
      logic busy;
      logic done;
   } core_ctl_type;

   function automatic word_type round_const(input logic [5:0] idx);
      word_type k;
      case (idx)
         6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
         6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
         6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
         6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
         6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
         6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
         6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
         6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
         6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
         6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
         6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
         6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
         default: k = 32'hc67178f2;
      endcase
      return k;
   endfunction

   function automatic word_type init_hash(input logic [2:0] idx);
      word_type h;
      case (idx)
         3'd0: h = 32'h6a09e667;
         3'd1: h = 32'hbb67ae85;
         3'd2: h = 32'h3c6ef372;
         3'd3: h = 32'ha54ff53a;
         3'd4: h = 32'h510e527f;
         3'd5: h = 32'h9b05688c;
         3'd6: h = 32'h1f83d9ab;
         default: h = 32'h5be0cd19;
      endcase
      return h;
   endfunction

   function automatic word_type rotr(input word_type x, input int unsigned n);
      return (x >> n) | (x << (WORD_W - n));
   endfunction

endpackage

### hw/rtl/sha256_core.sv
// Compression core: 64 rounds, one per cycle except that rounds 0..15 wait for
// word_valid; the rolling schedule sits in a 16-word memory. Depends on sha256_pkg and assert_macros.svh.
`include "assert_macros.svh"
module sha256_core
   import sha256_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,       // begin a block; word 0 follows with word_valid
   input  logic         word_valid,  // block word t is on word_in
   input  word_type     word_in,
   input  word_type     hin [8],
   output logic         busy,
   output logic         done,        // one-cycle pulse, hout valid
   output word_type     hout [8]
);

   // Schedule memory: one write and two reads per cycle, the write only when the round steps; read data registered.
   // Round t needs w[t-2], w[t-7], w[t-15], w[t-16]; reads of w[t-15] and w[t-16]
   // come from the memory a cycle ahead; w[t-2] and w[t-7] from a short tap line.
   word_type sched_mem [16];
   word_type rd15_ff, rd16_ff;
   word_type tap_ff [7];           // tap_ff[0] = w[t-1] ... tap_ff[6] = w[t-7]
   word_type tap_in [7];

   logic [6:0] round_ff, round_in;  // 0..64, 64 = done
   logic       run_ff, run_in;
   word_type   var_ff [8];
   word_type   var_in [8];

   logic [5:0] rnd;
   word_type   w_cur, s0, s1, t1, t2, ev, av;
   logic [3:0] rd15_addr, rd16_addr;

   assign rnd = round_ff[5:0];

   always_comb begin
      s0 = rotr(rd15_ff, 7) ^ rotr(rd15_ff, 18) ^ (rd15_ff >> 3);
      s1 = rotr(tap_ff[1], 17) ^ rotr(tap_ff[1], 19) ^ (tap_ff[1] >> 10);
      if (rnd < 6'd16) begin
         w_cur = word_in;
      end else begin
         w_cur = rd16_ff + s0 + tap_ff[6] + s1;
      end
      ev = var_ff[4];
      av = var_ff[0];
      t1 = var_ff[7] + (rotr(ev, 6) ^ rotr(ev, 11) ^ rotr(ev, 25)) +
           ((ev & var_ff[5]) ^ (~ev & var_ff[6])) + round_const(rnd) + w_cur;
      t2 = (rotr(av, 2) ^ rotr(av, 13) ^ rotr(av, 22)) +
           ((av & var_ff[1]) ^ (av & var_ff[2]) ^ (var_ff[1] & var_ff[2]));
      // Addresses for the next round t+1: w[t-14] and w[t-15].
      rd15_addr = rnd[3:0] + 4'd2;
      rd16_addr = rnd[3:0] + 4'd1;
   end

   logic step;
   assign step = run_ff && (rnd >= 6'd16 || word_valid);

   always_comb begin
      round_in = round_ff;
      run_in   = run_ff;
      for (int j = 0; j < 8; j++) var_in[j] = var_ff[j];
      for (int j = 0; j < 7; j++) tap_in[j] = tap_ff[j];
      if (start) begin
         run_in   = 1'b1;
         round_in = '0;
         for (int j = 0; j < 8; j++) var_in[j] = hin[j];
      end else if (step) begin
         round_in = round_ff + 7'd1;
         if (round_ff == 7'(NUM_ROUNDS - 1)) run_in = 1'b0;
         var_in[7] = var_ff[6];
         var_in[6] = var_ff[5];
         var_in[5] = var_ff[4];
         var_in[4] = var_ff[3] + t1;
         var_in[3] = var_ff[2];
         var_in[2] = var_ff[1];
         var_in[1] = var_ff[0];
         var_in[0] = t1 + t2;
         tap_in[0] = w_cur;
         for (int j = 1; j < 7; j++) tap_in[j] = tap_ff[j-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= 1'b0;
         round_ff <= '0;
      end else begin
         run_ff   <= run_in;
         round_ff <= round_in;
      end
      for (int j = 0; j < 8; j++) var_ff[j] <= var_in[j];
      for (int j = 0; j < 7; j++) tap_ff[j] <= tap_in[j];
   end

   // Memory port: write the current schedule word, read two for the next round.
   // Round t writes w[t] at t%16 while reading (t+2)%16 and (t+1)%16; these never
   // collide with the write address, so no forwarding is needed.
   always_ff @(posedge clock) begin
      if (step) begin
         sched_mem[rnd[3:0]] <= w_cur;
      end
      rd15_ff <= sched_mem[rd15_addr];
      rd16_ff <= sched_mem[rd16_addr];
   end

   logic done_ff;
   always_ff @(posedge clock) begin
      if (reset) done_ff <= 1'b0;
      else       done_ff <= step && (round_ff == 7'(NUM_ROUNDS - 1));
   end

   assign busy = run_ff;
   assign done = done_ff;
   always_comb begin
      for (int j = 0; j < 8; j++) hout[j] = hin[j] + var_ff[j];
   end

   `ASSERT_IMPLY(a_no_start_busy, clock, reset, start, !run_ff, "start while core busy")
   `ASSERT_NEXT(a_done_ends_run, clock, reset, done_ff, !run_ff || start, "core still runs after done")
   `ASSERT_IMPLY(a_round_range, clock, reset, run_ff, round_ff < 7'(NUM_ROUNDS), "round out of range")

endmodule

### hw/rtl/sha256_byte_stream_hash.sv
// SHA-256 over a byte stream: the request channel delivers message bytes, the
// response channel returns eight digest words per message.
// Header for the user of the block:
//   Request: req_tdata[7:0] is the byte, req_tuser marks it valid, req_tlast
//   ends the message (a request with req_tuser low and req_tlast high closes
//   the message as it stands, so an empty message is fine).
//   Bytes are packed into 32-bit words for the round core. Every fourth valid
//   byte is followed by ST_FEED, with req_tready low while the word is handed
//   over; word 0 of a block first waits for the previous block to finish and
//   then starts the core before the word is handed over. On a last request the
//   block pads (0x80, zeros, 64-bit bit length) and runs one or two more blocks;
//   once the core's done pulse has moved it to ST_OUT, it presents eight
//   response words, word 0 first, rsp_tlast on word 7. The response words are
//   held while rsp_tready is low; no new request is taken until all eight are
//   gone and state ST_RST has reloaded the initial hash.
//   Reset (synchronous, active high) returns to the initial hash with an empty
//   message; no clearing pass is needed.
`include "assert_macros.svh"
module sha256_byte_stream_hash
   import sha256_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] byte_valid
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] digest_word, [34:32] word_index, zeros
   output logic        rsp_tlast    // last_word
);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_FEED = 6'b000010,   // waiting for the core to take a word
      ST_PAD  = 6'b000100,   // generating padding words
      ST_WAIT = 6'b001000,   // final block compressing
      ST_OUT  = 6'b010000,
      ST_RST  = 6'b100000    // reload the initial hash
   } state_type;

   state_type  state_ff, state_in;
   word_type   hash_ff [8];
   word_type   hash_in [8];
   word_type   acc_ff, acc_in;      // byte packer
   logic [5:0] fill_ff, fill_in;    // bytes in block
   logic [63:0] len_ff, len_in;
   logic       pad_second_ff, pad_second_in;
   logic       closing_ff, closing_in;   // pad block(s) follow
   logic [3:0] pwidx_ff, pwidx_in;       // word index within pad block
   logic       pad80_ff, pad80_in;       // 0x80 byte already placed
   logic [2:0] oidx_ff, oidx_in;
   logic       started_ff, started_in;   // core started, word 0 not yet taken

   logic       core_start, core_wv, core_busy, core_done;
   word_type   core_word, core_hout [8];
   core_ctl_type ctl;

   sha256_core u_core (
      .clock(clock), .reset(reset), .start(core_start), .word_valid(core_wv),
      .word_in(core_word), .hin(hash_ff), .busy(core_busy), .done(core_done),
      .hout(core_hout)
   );

   assign ctl.start = core_start;
   assign ctl.busy  = core_busy;
   assign ctl.done  = core_done;

   logic acc_req;
   word_type packed_w;
   logic [63:0] bits;
   assign acc_req = req_tvalid && req_tready;
   assign bits    = {len_ff[60:0], 3'b000};

   always_comb begin
      state_in = state_ff;
      acc_in = acc_ff; fill_in = fill_ff; len_in = len_ff;
      pad_second_in = pad_second_ff; closing_in = closing_ff;
      pwidx_in = pwidx_ff; pad80_in = pad80_ff; oidx_in = oidx_ff;
      started_in = started_ff;
      for (int j = 0; j < 8; j++) hash_in[j] = hash_ff[j];
      req_tready = 1'b0;
      core_start = 1'b0; core_wv = 1'b0; core_word = acc_ff;
      packed_w = acc_ff;

      if (core_done) begin
         for (int j = 0; j < 8; j++) hash_in[j] = core_hout[j];
      end

      case (state_ff)
         ST_IDLE: begin
            req_tready = !core_done;
            if (acc_req) begin
               if (req_tuser) begin
                  packed_w = {acc_ff[23:0], req_tdata};
                  acc_in  = packed_w;
                  fill_in = fill_ff + 6'd1;
                  len_in  = len_ff + 64'd1;
                  if (fill_ff[1:0] == 2'd3) begin
                     // Word complete: hand it to the core from ST_FEED.
                     state_in = ST_FEED;
                  end
               end
               if (req_tlast) begin
                  closing_in = 1'b1;
                  if (!(req_tuser && fill_ff[1:0] == 2'd3)) state_in = ST_PAD;
               end
            end
         end
         ST_FEED: begin
            // Word 0 needs a start pulse first; later words are taken while busy.
            core_word = acc_ff;
            if (fill_ff[5:2] == 4'd1 && !started_ff) begin
               if (!core_busy && !core_done) begin
                  core_start = 1'b1;
                  started_in = 1'b1;
               end
            end else if (core_busy) begin
               core_wv = 1'b1;
               started_in = 1'b0;
               state_in = closing_ff ? ST_PAD : ST_IDLE;
            end
         end
         ST_PAD: begin
            // Build one pad word: the partial word in acc_ff with 0x80, then zeros and the bit length.
            logic [3:0] widx;
            logic [1:0] nb;
            widx = pwidx_ff;
            nb   = fill_ff[1:0];
            if (!pad80_ff) begin
               widx = fill_ff[5:2];
               case (nb)
                  2'd0: packed_w = {PAD_BYTE, 24'h0};
                  2'd1: packed_w = {acc_ff[7:0], PAD_BYTE, 16'h0};
                  2'd2: packed_w = {acc_ff[15:0], PAD_BYTE, 8'h0};
                  default: packed_w = {acc_ff[23:0], PAD_BYTE};
               endcase
            end else if (widx == 4'd14 && !pad_second_ff) begin
               packed_w = bits[63:32];
            end else if (widx == 4'd15 && !pad_second_ff) begin
               packed_w = bits[31:0];
            end else begin
               packed_w = '0;
            end
            core_word = packed_w;
            if (widx == 4'd0 && !started_ff) begin
               if (!core_busy && !core_done) begin
                  core_start = 1'b1;
                  started_in = 1'b1;
               end
            end else if (core_busy) begin
               core_wv = 1'b1;
               started_in = 1'b0;
               pad80_in = 1'b1;
               pwidx_in = widx + 4'd1;
               if (!pad80_ff && widx >= 4'd14) pad_second_in = 1'b1;
               if (widx == 4'd15) begin
                  if (pad_second_ff || (!pad80_ff && widx >= 4'd14)) begin
                     pad_second_in = 1'b0;
                     pwidx_in = 4'd0;
                  end else begin
                     state_in = ST_WAIT;
                  end
               end
            end
            // A second pad block restarts at word 0 with only zeros and length.
            if (pad_second_ff && widx == 4'd0 && pad80_ff) begin
               packed_w = '0;
               core_word = packed_w;
            end
         end
         ST_WAIT: begin
            if (core_done) begin
               state_in = ST_OUT;
               oidx_in = '0;
            end
         end
         ST_OUT: begin
            if (rsp_tready) begin
               oidx_in = oidx_ff + 3'd1;
               if (oidx_ff == 3'd7) state_in = ST_RST;
            end
         end
         ST_RST: begin
            for (int j = 0; j < 8; j++) hash_in[j] = init_hash(3'(j));
            fill_in = '0; len_in = '0; closing_in = 1'b0;
            pwidx_in = '0; pad80_in = 1'b0; pad_second_in = 1'b0;
            started_in = 1'b0;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff <= '0; len_ff <= '0;
         closing_ff <= 1'b0; pad_second_ff <= 1'b0;
         pwidx_ff <= '0; pad80_ff <= 1'b0; oidx_ff <= '0;
         started_ff <= 1'b0;
         for (int j = 0; j < 8; j++) hash_ff[j] <= init_hash(3'(j));
      end else begin
         state_ff <= state_in;
         fill_ff <= fill_in; len_ff <= len_in;
         closing_ff <= closing_in; pad_second_ff <= pad_second_in;
         pwidx_ff <= pwidx_in; pad80_ff <= pad80_in; oidx_ff <= oidx_in;
         started_ff <= started_in;
         for (int j = 0; j < 8; j++) hash_ff[j] <= hash_in[j];
      end
      acc_ff <= acc_in;
   end

   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata  = {5'b0, oidx_ff, hash_ff[oidx_ff]};
   assign rsp_tlast  = (oidx_ff == 3'd7);

   `ASSERT_IMPLY(a_no_req_out, clock, reset, rsp_tvalid, !req_tready, "request taken during output")
   `ASSERT_IMPLY(a_start_idle, clock, reset, ctl.start, !ctl.busy, "core started while busy")
   `ASSERT_IMPLY(a_out_core_idle, clock, reset, rsp_tvalid, !ctl.busy, "core busy during output")

endmodule

### verif/sha256_byte_stream_hash_tb.sv
// Testbench for the streaming SHA-256 block: drives message bytes, predicts
// the eight digest words per message and checks them. Depends on sha256_pkg.
`timescale 1ns / 1ps

module sha256_byte_stream_hash_tb
   import sha256_pkg::*;
;

   typedef struct {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       last_byte;
   } req_item_type;

   typedef struct {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } digest_item_type;

   localparam int WATCHDOG_LIMIT = 20000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tuser;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;

   req_item_type    pending_reqs[$];
   digest_item_type expected_words[$];
   int              error_count;
   int              messages_sent;
   int              words_checked;
   int              idle_pct;
   int              hold_off_cycles;
   bit              stall_sender;
   int              quiet_cycles;

   // Predictor state.
   logic [31:0] hash_state[8];
   logic [7:0]  block_buf[64];
   int          block_fill;
   logic [63:0] byte_total;

   sha256_byte_stream_hash uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [31:0] ror32(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   task automatic clear_hash_state();
      for (int j = 0; j < 8; j++)
         hash_state[j] = init_hash(j[2:0]);
      block_fill = 0;
      byte_total = '0;
   endtask

   task automatic compress_buffer();
      logic [31:0] w[64];
      logic [31:0] v[8];
      logic [31:0] t1, t2, s0, s1;
      for (int t = 0; t < 16; t++)
         w[t] = {block_buf[4*t], block_buf[4*t+1], block_buf[4*t+2], block_buf[4*t+3]};
      for (int t = 16; t < 64; t++) begin
         s0 = ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3);
         s1 = ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10);
         w[t] = w[t-16] + s0 + w[t-7] + s1;
      end
      for (int j = 0; j < 8; j++)
         v[j] = hash_state[j];
      for (int t = 0; t < 64; t++) begin
         t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
              + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_const(t[5:0]) + w[t];
         t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
              + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int j = 0; j < 8; j++)
         hash_state[j] += v[j];
   endtask

   task automatic predict_digest(req_item_type it);
      logic [63:0] bit_len;
      digest_item_type d;
      if (it.byte_valid) begin
         block_buf[block_fill] = it.data_byte;
         block_fill++;
         byte_total++;
         if (block_fill == 64) begin
            compress_buffer();
            block_fill = 0;
         end
      end
      if (!it.last_byte) return;
      bit_len = byte_total << 3;
      block_buf[block_fill] = PAD_BYTE;
      block_fill++;
      if (block_fill > 56) begin
         for (int i = block_fill; i < 64; i++) block_buf[i] = 8'h00;
         compress_buffer();
         block_fill = 0;
      end
      for (int i = block_fill; i < 56; i++) block_buf[i] = 8'h00;
      for (int i = 0; i < 8; i++) block_buf[56+i] = bit_len[63-8*i -: 8];
      compress_buffer();
      for (int i = 0; i < 8; i++) begin
         d.digest_word = hash_state[i];
         d.word_index  = i[2:0];
         d.last_word   = (i == 7);
         expected_words.push_back(d);
      end
      clear_hash_state();
   endtask

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      error_count++;
      $display("[%0t] mismatch %s: got %h expected %h", $time, what, got, want);
   endtask

   task automatic queue_message(int len, bit empty_close);
      req_item_type it;
      for (int i = 0; i < len; i++) begin
         it.data_byte  = 8'($urandom_range(0, 255));
         it.byte_valid = 1'b1;
         it.last_byte  = (!empty_close && i == len - 1);
         pending_reqs.push_back(it);
         // Occasional ignored byte after a message byte.
         if ($urandom_range(0, 9) == 0) begin
            it.byte_valid = 1'b0;
            it.last_byte  = 1'b0;
            it.data_byte  = 8'($urandom_range(0, 255));
            pending_reqs.push_back(it);
         end
      end
      if (empty_close || len == 0) begin
         it.data_byte  = 8'($urandom_range(0, 255));
         it.byte_valid = 1'b0;
         it.last_byte  = 1'b1;
         pending_reqs.push_back(it);
      end
      messages_sent++;
   endtask

   // Returns once every queued request is accepted and every digest checked.
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_reqs.size() > 0 || req_tvalid || expected_words.size() > 0);
   endtask

   // Driver.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) predict_digest('{req_tdata, req_tuser, req_tlast});
         if (pending_reqs.size() > 0 && !stall_sender && $urandom_range(0, 99) >= idle_pct) begin
            req_item_type it;
            it = pending_reqs.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= it.data_byte;
            req_tuser  <= it.byte_valid;
            req_tlast  <= it.last_byte;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Monitor and response back-pressure.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_words.size() == 0) begin
               report_mismatch("unexpected word", rsp_tdata[31:0], 32'h0);
            end else begin
               digest_item_type d;
               d = expected_words.pop_front();
               if (rsp_tdata[31:0] !== d.digest_word)
                  report_mismatch("digest_word", rsp_tdata[31:0], d.digest_word);
               if (rsp_tdata[34:32] !== d.word_index)
                  report_mismatch("word_index", 32'(rsp_tdata[34:32]), 32'(d.word_index));
               if (rsp_tlast !== d.last_word)
                  report_mismatch("last_word", 32'(rsp_tlast), 32'(d.last_word));
               if (rsp_tdata[39:35] !== 5'b0)
                  report_mismatch("padding bits", 32'(rsp_tdata[39:35]), 32'h0);
               words_checked++;
            end
         end
         if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= idle_pct);
         end
      end
   end

   // Watchdog on cycles with no handshake on either side.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired with %0d words outstanding", expected_words.size());
         $display("** sha256_byte_stream_hash: FAILED **");
         $finish;
      end
   end

   initial begin
      req_item_type it;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      req_tlast = 1'b0;
      rsp_tready = 1'b0;
      error_count = 0;
      messages_sent = 0;
      words_checked = 0;
      idle_pct = 36;
      hold_off_cycles = 0;
      stall_sender = 1'b0;
      quiet_cycles = 0;
      clear_hash_state();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty message, single extreme bytes closed on their own
      // last request, ignored bytes, and short messages with both closings.
      queue_message(0, 1'b1);
      it = '{8'hff, 1'b1, 1'b1};
      pending_reqs.push_back(it);
      it = '{8'h00, 1'b1, 1'b1};
      pending_reqs.push_back(it);
      it = '{8'h5a, 1'b0, 1'b0};
      pending_reqs.push_back(it);
      it = '{8'ha5, 1'b0, 1'b1};
      pending_reqs.push_back(it);
      queue_message(3, 1'b0);
      queue_message(5, 1'b1);
      wait_drained();

      // Boundary length where padding spills into a second block.
      queue_message(56, 1'b0);
      wait_drained();

      // Long receiver hold-off while the sender keeps offering.
      hold_off_cycles = 400;
      queue_message(2, 1'b0);
      queue_message(1, 1'b0);
      queue_message(4, 1'b0);
      wait_drained();

      // Sender pauses with a message queued, then resumes.
      stall_sender = 1'b1;
      queue_message(7, 1'b0);
      repeat (50) @(posedge clock);
      stall_sender = 1'b0;
      wait_drained();

      // A full block followed by an empty close, with no idling on either side.
      idle_pct = 0;
      queue_message(64, 1'b1);
      wait_drained();
      idle_pct = 36;
      for (int m = 0; m < 2; m++)
         queue_message(int'($urandom_range(0, 20)), $urandom_range(0, 3) == 0);

      wait_drained();
      repeat (200) @(posedge clock);

      $display("covered %0d messages (empty, boundary, multi-block), %0d digest words",
               messages_sent, words_checked);
      if (error_count == 0) begin
         $display("** sha256_byte_stream_hash: PASSED **");
      end else begin
         $display("** sha256_byte_stream_hash: FAILED **");
      end
      $finish;
   end

endmodule
